>>> sv/lsmpq_pkg.sv
// Shared types and codes for the linear-scan max priority queue.
// No dependencies; the controller, datapath, top level and checker import this package.
`timescale 1ns / 1ps

package lsmpq_pkg;

    // Operation codes carried by the kind field of a request beat.
    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_CHANGE  = 2'd3
    } t_kind;

    // Status codes carried by a response beat.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request payload
        logic simple;      // finish an insert or an operation on an empty store
        logic scan_start;  // set up a compaction pass
        logic scan;        // run the compaction pass
        logic publish;     // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;       // captured operation
        logic  empty;      // store holds no entry
        logic  scan_done;  // last entry of the pass is processed this cycle
    } t_dp_stat;

endpackage

>>> sv/lsmpq_req_if.sv
// Request channel of the priority queue: valid/ready handshake and payload.
// Depends on nothing; widths come from its parameter.
`timescale 1ns / 1ps

interface lsmpq_req_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] new_value;

    modport source (output valid, output kind, output value, output new_value, input ready);
    modport sink   (input valid, input kind, input value, input new_value, output ready);
    modport monitor (input valid, input ready, input kind, input value, input new_value);
endinterface

>>> sv/lsmpq_rsp_if.sv
// Response channel of the priority queue: valid/ready handshake and payload.
// Depends on nothing; widths come from its parameters.
`timescale 1ns / 1ps

interface lsmpq_rsp_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 5
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] extracted;
    logic [1:0]             status;
    logic [VALUE_WIDTH-1:0] current_max;
    logic [COUNT_WIDTH-1:0] occupancy;

    modport source (output valid, output extracted, output status, output current_max,
                    output occupancy, input ready);
    modport sink   (input valid, input extracted, input status, input current_max,
                    input occupancy, output ready);
    modport monitor (input valid, input ready, input extracted, input status,
                     input current_max, input occupancy);
endinterface

>>> sv/lsmpq_ctrl.sv
// Controller of the priority queue: sequences one operation at a time and
// owns both handshakes. Depends on lsmpq_pkg.
`timescale 1ns / 1ps

module lsmpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  lsmpq_pkg::t_dp_stat i_stat,
    output lsmpq_pkg::t_dp_cmd  o_cmd
);
    import lsmpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_RESULT
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_dp_cmd w_cmd;
    logic    w_out_free;

    // The output register is free when empty or when its beat leaves now.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_stat.kind == KIND_INSERT || i_stat.empty) begin
                    w_cmd.simple = 1'b1;
                    n_state      = S_RESULT;
                end else begin
                    w_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    w_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    // State and output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> sv/lsmpq_dp.sv
// Datapath of the priority queue: entry memory, entry count, running maximum,
// two-comparator compaction pass and the output register. Depends on lsmpq_pkg.
`timescale 1ns / 1ps

module lsmpq_dp #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32,
    parameter int ADDR_WIDTH  = $clog2(DEPTH),
    parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lsmpq_pkg::t_dp_cmd      i_cmd,
    output lsmpq_pkg::t_dp_stat     o_stat,
    input  logic [1:0]              i_kind,
    input  logic [VALUE_WIDTH-1:0]  i_value,
    input  logic [VALUE_WIDTH-1:0]  i_new_value,
    output logic [VALUE_WIDTH-1:0]  o_extracted,
    output logic [1:0]              o_status,
    output logic [VALUE_WIDTH-1:0]  o_current_max,
    output logic [COUNT_WIDTH-1:0]  o_occupancy
);
    import lsmpq_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(DEPTH);

    // Entry store; contents are undefined until written.
    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    // Captured operation.
    t_kind                  r_kind;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_new_value;

    // Store state.
    logic [COUNT_WIDTH-1:0] r_count;
    logic [VALUE_WIDTH-1:0] r_max;

    // Pass state.
    logic [COUNT_WIDTH-1:0] r_rd_idx;
    logic [COUNT_WIDTH-1:0] r_wr_idx;
    logic [VALUE_WIDTH-1:0] r_rdata;
    logic                   r_pv;
    logic                   r_plast;
    logic [VALUE_WIDTH-1:0] r_key;
    logic                   r_dropped;
    logic                   r_found;
    logic [VALUE_WIDTH-1:0] r_new_max;

    // Finished result, waiting for the output register.
    logic [VALUE_WIDTH-1:0] r_res_ext;
    t_status                r_res_status;

    // Output register.
    logic [VALUE_WIDTH-1:0] r_out_ext;
    t_status                r_out_status;
    logic [VALUE_WIDTH-1:0] r_out_max;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic                   w_issue;
    logic                   w_proc;
    logic                   w_match;
    logic                   w_drop;
    logic                   w_repl;
    logic [VALUE_WIDTH-1:0] w_wval;
    logic [VALUE_WIDTH-1:0] n_new_max;
    logic [COUNT_WIDTH-1:0] n_wr_idx;
    logic                   w_full;
    logic                   w_we;
    logic [ADDR_WIDTH-1:0]  w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;

    assign w_full  = (r_count == FullCount);
    assign w_issue = i_cmd.scan && (r_rd_idx != r_count);
    assign w_proc  = i_cmd.scan && r_pv;

    // One element of the compaction pass: drop, replace or keep it.
    always_comb begin
        w_match = (r_rdata == r_key);
        w_drop  = 1'b0;
        w_repl  = 1'b0;
        case (r_kind)
            KIND_EXTRACT: w_drop = w_match && !r_dropped;
            KIND_REMOVE:  w_drop = w_match;
            KIND_CHANGE:  w_repl = w_match && !r_found;
            default:      w_drop = 1'b0;
        endcase
        w_wval    = w_repl ? r_new_value : r_rdata;
        n_new_max = (!w_drop && w_wval > r_new_max) ? w_wval : r_new_max;
        n_wr_idx  = w_drop ? r_wr_idx : r_wr_idx + COUNT_WIDTH'(1);
    end

    // Memory write port: insert at the tail, or a kept element during the pass.
    always_comb begin
        if (i_cmd.simple) begin
            w_we    = (r_kind == KIND_INSERT) && !w_full;
            w_waddr = r_count[ADDR_WIDTH-1:0];
            w_wdata = r_value;
        end else begin
            w_we    = w_proc && !w_drop;
            w_waddr = r_wr_idx[ADDR_WIDTH-1:0];
            w_wdata = w_wval;
        end
    end

    // Entry memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rdata <= mem[r_rd_idx[ADDR_WIDTH-1:0]];
        end
    end

    // Read pointer and pass valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_plast  <= 1'b0;
            r_rd_idx <= '0;
        end else if (i_cmd.scan_start) begin
            r_pv     <= 1'b0;
            r_plast  <= 1'b0;
            r_rd_idx <= '0;
        end else if (i_cmd.scan) begin
            r_pv    <= w_issue;
            r_plast <= (r_rd_idx + COUNT_WIDTH'(1)) == r_count;
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + COUNT_WIDTH'(1);
            end
        end
    end

    // Store state: entry count and current maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_max   <= '0;
        end else if (i_cmd.simple) begin
            if (r_kind == KIND_INSERT && !w_full) begin
                r_count <= r_count + COUNT_WIDTH'(1);
                if (r_value > r_max) begin
                    r_max <= r_value;
                end
            end
        end else if (w_proc && r_plast) begin
            r_count <= n_wr_idx;
            r_max   <= n_new_max;
        end
    end

    // Capture of the request and bookkeeping of the pass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind      <= t_kind'(i_kind);
            r_value     <= i_value;
            r_new_value <= i_new_value;
        end
        if (i_cmd.scan_start) begin
            r_key     <= (r_kind == KIND_EXTRACT) ? r_max : r_value;
            r_wr_idx  <= '0;
            r_dropped <= 1'b0;
            r_found   <= 1'b0;
            r_new_max <= '0;
        end else if (w_proc) begin
            r_wr_idx  <= n_wr_idx;
            r_dropped <= r_dropped || w_drop;
            r_found   <= r_found || w_repl;
            r_new_max <= n_new_max;
        end
    end

    // Result of the operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.simple) begin
            r_res_ext <= '0;
            case (r_kind)
                KIND_INSERT:  r_res_status <= w_full ? ST_FULL : ST_OK;
                KIND_EXTRACT: r_res_status <= ST_EMPTY;
                default:      r_res_status <= ST_NOT_FOUND;
            endcase
        end else if (w_proc && r_plast) begin
            case (r_kind)
                KIND_EXTRACT: begin
                    r_res_ext    <= r_max;
                    r_res_status <= ST_OK;
                end
                KIND_REMOVE: begin
                    r_res_ext    <= '0;
                    r_res_status <= (r_dropped || w_drop) ? ST_OK : ST_NOT_FOUND;
                end
                default: begin
                    r_res_ext    <= '0;
                    r_res_status <= (r_found || w_repl) ? ST_OK : ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Output register, loaded when the controller publishes a result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_ext    <= r_res_ext;
            r_out_status <= r_res_status;
            r_out_max    <= r_max;
            r_out_count  <= r_count;
        end
    end

    assign o_extracted   = r_out_ext;
    assign o_status      = r_out_status;
    assign o_current_max = r_out_max;
    assign o_occupancy   = r_out_count;

    assign o_stat.kind      = r_kind;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.scan_done = w_proc && r_plast;

endmodule

>>> sv/linear_scan_max_priority_queue_core.sv
// Top level of the linear-scan max priority queue: controller plus datapath.
// Depends on lsmpq_pkg, lsmpq_req_if, lsmpq_rsp_if, lsmpq_ctrl and lsmpq_dp.
//
// Usage:
//   i_req carries one operation per beat (kind, value, new_value); o_rsp returns
//   exactly one beat per request (extracted, status, current_max, occupancy),
//   in request order. Both channels use valid/ready; a beat moves when both are
//   high at a rising edge of i_clk.
//   An insert, and any operation on an empty store, finishes without a pass;
//   extract, remove and change stream every stored entry once through an
//   equality and a magnitude comparator over the memory's one read port, so
//   their response comes later as occupancy grows.
//   i_req.ready is high while no operation is in progress; a new request is
//   taken while the previous response still waits in the output register.
//   When the receiver stalls, the response holds and a finished operation waits
//   until the output register frees up.
//   i_rst_n is synchronous and active low; reset empties the store at once, with
//   no clearing pass, and drops any response not yet taken.
`timescale 1ns / 1ps

module linear_scan_max_priority_queue_core #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsmpq_req_if.sink   i_req,
    lsmpq_rsp_if.source o_rsp
);
    import lsmpq_pkg::*;

    localparam int AddrWidth  = $clog2(DEPTH);
    localparam int CountWidth = $clog2(DEPTH + 1);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencing and handshakes.
    lsmpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Storage, scan and result registers.
    lsmpq_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ADDR_WIDTH  (AddrWidth),
        .COUNT_WIDTH (CountWidth)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_kind        (i_req.kind),
        .i_value       (i_req.value),
        .i_new_value   (i_req.new_value),
        .o_extracted   (o_rsp.extracted),
        .o_status      (o_rsp.status),
        .o_current_max (o_rsp.current_max),
        .o_occupancy   (o_rsp.occupancy)
    );

endmodule

>>> sv/lsmpq_checker.sv
// Port-level checks of the priority queue response channel, bound to the top.
// Depends on lsmpq_pkg and linear_scan_max_priority_queue_core.
`timescale 1ns / 1ps

module lsmpq_checker #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [VALUE_WIDTH-1:0]        i_rsp_extracted,
    input logic [1:0]                    i_rsp_status,
    input logic [VALUE_WIDTH-1:0]        i_rsp_current_max,
    input logic [$clog2(DEPTH + 1)-1:0]  i_rsp_occupancy
);
    import lsmpq_pkg::*;

    localparam int CountWidth = $clog2(DEPTH + 1);
    localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

    // A stalled response beat keeps its status, extracted value and occupancy.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_extracted) && $stable(i_rsp_occupancy))
        else $error("response beat changed while stalled");

    // The store never reports more entries than its depth.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_occupancy <= FullCount)
        else $error("occupancy above depth");

    // An empty store reports a zero maximum, and an empty extract returns zero.
    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_occupancy == '0 |-> i_rsp_current_max == '0
            && (i_rsp_status != ST_EMPTY || i_rsp_extracted == '0))
        else $error("empty store with nonzero value");

    // Full status only when the store is full; empty status only when empty.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status != ST_FULL || i_rsp_occupancy == FullCount)
            && (i_rsp_status != ST_EMPTY || i_rsp_occupancy == '0))
        else $error("status disagrees with occupancy");

    // After a successful extract of a nonzero value, the remaining maximum
    // cannot exceed what was extracted.
    a_extract_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_OK && i_rsp_extracted != '0
            |-> i_rsp_current_max <= i_rsp_extracted)
        else $error("remaining maximum above extracted value");

endmodule

bind linear_scan_max_priority_queue_core lsmpq_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_lsmpq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_extracted   (o_rsp.extracted),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_current_max (o_rsp.current_max),
    .i_rsp_occupancy   (o_rsp.occupancy)
);
